// ----- design/bptc_pkg.sv -----
// ----------------------------------------------------------------------------
// bptc_pkg
// Shared widths, limits, register codes and the calibration coefficient
// record of the barometric compensation pipeline.
// ----------------------------------------------------------------------------
package bptc_pkg;

  // raw readings and scale factors
  localparam int RAW_W    = 24;
  localparam int SCALE_W  = 23;
  localparam int FRAC_W   = 24;
  localparam int QMAG_W   = 30;
  localparam int CFG_W    = 64;
  localparam int CFG_IDX_W = 3;

  localparam logic [SCALE_W-1:0] SCALE_MIN = 23'd253952;
  localparam logic [SCALE_W-1:0] SCALE_MAX = 23'd7864320;
  localparam logic [SCALE_W-1:0] SCALE_RST = 23'd524288;

  // results
  localparam int TEMP_W  = 24;
  localparam int PRESS_W = 32;
  localparam int SUM_W   = 61;

  // pressure divide by 25 after the shift by 16: saturation bound and digits
  localparam int PM_W    = SUM_W - 16;
  localparam int PMAG_W  = 36;
  localparam int DIG_W   = 4;
  localparam logic [PM_W-1:0] PSAT_LIM = 45'd53687091200;
  localparam logic [PRESS_W-1:0] PRESS_MAX = 32'h7fff_ffff;
  localparam logic [PRESS_W-1:0] PRESS_MIN = 32'h8000_0000;
  localparam logic [TEMP_W-1:0]  TEMP_MAX  = 24'h7f_ffff;
  localparam logic [TEMP_W-1:0]  TEMP_MIN  = 24'h80_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP_COEF   = 3'd0,
    CFG_PRESS_HIGH  = 3'd1,
    CFG_PRESS_MID   = 3'd2,
    CFG_PRESS_LOW   = 3'd3,
    CFG_TEMP_SCALE  = 3'd4,
    CFG_PRESS_SCALE = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [11:0] c0;
    logic [11:0] c1;
    logic [19:0] c00;
    logic [19:0] c10;
    logic [15:0] c01;
    logic [15:0] c11;
    logic [15:0] c20;
    logic [15:0] c21;
    logic [15:0] c30;
  } coef_t;

endpackage

// ----- design/baro_temp_pressure_compensation.sv -----
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// Throughput: one pair per cycle while no result is held; depth is set by the
// 30-stage restoring divider for the scaled values, the polynomial datapath
// and the 9-stage divide by 25 on pressure.
// A held result stalls the whole pipeline; nothing is lost or repeated.
// Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bptc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bptc_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [bptc_pkg::RAW_W-1:0]    raw_temperature_i,
  input  logic signed [bptc_pkg::RAW_W-1:0]    raw_pressure_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [bptc_pkg::TEMP_W-1:0]   temperature_q_o,
  output logic signed [bptc_pkg::PRESS_W-1:0]  pressure_q_o
);
  import bptc_pkg::*;

  logic [23:0]        temp_coef_q;
  logic [39:0]        press_high_q;
  logic [63:0]        press_mid_q;
  logic [15:0]        press_low_q;
  logic [SCALE_W-1:0] temp_scale_q;
  logic [SCALE_W-1:0] press_scale_q;

  coef_t              coef;
  logic               en;
  logic               tdiv_valid, pdiv_valid, poly_valid;
  logic               t_neg, p_neg;
  logic [QMAG_W-1:0]  t_mag, p_mag;
  logic signed [SUM_W-1:0] sum;
  logic [TEMP_W-1:0]  temp;
  logic [TEMP_W-1:0]  temp_res;
  logic [PRESS_W-1:0] press_res;

  // configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_coef_q   <= '0;
      press_high_q  <= '0;
      press_mid_q   <= '0;
      press_low_q   <= '0;
      temp_scale_q  <= SCALE_RST;
      press_scale_q <= SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TEMP_COEF:   temp_coef_q   <= cfg_wdata_i[23:0];
        CFG_PRESS_HIGH:  press_high_q  <= cfg_wdata_i[39:0];
        CFG_PRESS_MID:   press_mid_q   <= cfg_wdata_i;
        CFG_PRESS_LOW:   press_low_q   <= cfg_wdata_i[15:0];
        CFG_TEMP_SCALE:  temp_scale_q  <= cfg_wdata_i[SCALE_W-1:0];
        CFG_PRESS_SCALE: press_scale_q <= cfg_wdata_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // unpack calibration words
  assign coef.c0  = temp_coef_q[23:12];
  assign coef.c1  = temp_coef_q[11:0];
  assign coef.c00 = press_high_q[39:20];
  assign coef.c10 = press_high_q[19:0];
  assign coef.c01 = press_mid_q[63:48];
  assign coef.c11 = press_mid_q[47:32];
  assign coef.c20 = press_mid_q[31:16];
  assign coef.c21 = press_mid_q[15:0];
  assign coef.c30 = press_low_q;

  // hold every stage while the result waits
  assign in_stall_o = out_valid_o & out_stall_i;
  assign en         = ~in_stall_o;

  bptc_sdiv u_tdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .raw_i   (raw_temperature_i),
    .scale_i (temp_scale_q),
    .valid_o (tdiv_valid),
    .neg_o   (t_neg),
    .mag_o   (t_mag)
  );

  bptc_sdiv u_pdiv_sc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .raw_i   (raw_pressure_i),
    .scale_i (press_scale_q),
    .valid_o (pdiv_valid),
    .neg_o   (p_neg),
    .mag_o   (p_mag)
  );

  bptc_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (tdiv_valid & pdiv_valid),
    .coef_i  (coef),
    .t_mag_i (t_mag),
    .t_neg_i (t_neg),
    .p_mag_i (p_mag),
    .p_neg_i (p_neg),
    .valid_o (poly_valid),
    .sum_o   (sum),
    .temp_o  (temp)
  );

  bptc_pdiv u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (poly_valid),
    .sum_i   (sum),
    .temp_i  (temp),
    .valid_o (out_valid_o),
    .temp_o  (temp_res),
    .press_o (press_res)
  );

  assign temperature_q_o = $signed(temp_res);
  assign pressure_q_o    = $signed(press_res);

endmodule

// ----- design/bptc_sdiv.sv -----
// ----------------------------------------------------------------------------
// bptc_sdiv
// Pipelined restoring divider: |raw| * 2^24 / scale, one quotient bit per
// stage, sign carried alongside. The scale is clamped on entry.
// ----------------------------------------------------------------------------
module bptc_sdiv (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [bptc_pkg::RAW_W-1:0] raw_i,
  input  logic [bptc_pkg::SCALE_W-1:0]      scale_i,
  output logic                              valid_o,
  output logic                              neg_o,
  output logic [bptc_pkg::QMAG_W-1:0]       mag_o
);
  import bptc_pkg::*;

  localparam int NS  = QMAG_W;
  localparam int PRE = QMAG_W - FRAC_W;

  logic [SCALE_W-1:0] rem_q [0:NS];
  logic [QMAG_W-1:0]  sh_q  [0:NS];
  logic [SCALE_W-1:0] dv_q  [0:NS];
  logic               neg_q [0:NS];
  logic [NS:0]        vld_q;

  logic [SCALE_W:0]   trial_w [1:NS];
  logic               ge_w    [1:NS];
  logic [SCALE_W-1:0] rem_w   [1:NS];
  logic [SCALE_W-1:0] dv0_w;
  logic [RAW_W-1:0]   mag0_w;

  // clamp the scale, take the magnitude, then one trial subtract per stage
  always_comb begin
    if (scale_i < SCALE_MIN) begin
      dv0_w = SCALE_MIN;
    end else if (scale_i > SCALE_MAX) begin
      dv0_w = SCALE_MAX;
    end else begin
      dv0_w = scale_i;
    end
    mag0_w = raw_i[RAW_W-1] ? RAW_W'(-raw_i) : RAW_W'(raw_i);
    for (int s = 1; s <= NS; s++) begin
      trial_w[s] = {rem_q[s-1], sh_q[s-1][QMAG_W-1]};
      ge_w[s]    = trial_w[s] >= {1'b0, dv_q[s-1]};
      rem_w[s]   = ge_w[s] ? SCALE_W'(trial_w[s] - {1'b0, dv_q[s-1]})
                           : trial_w[s][SCALE_W-1:0];
    end
  end

  // advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-1:0], valid_i};
    end
  end

  // advance stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= {{(SCALE_W-RAW_W+PRE){1'b0}}, mag0_w[RAW_W-1:PRE]};
      sh_q[0]  <= {mag0_w[PRE-1:0], {FRAC_W{1'b0}}};
      dv_q[0]  <= dv0_w;
      neg_q[0] <= raw_i[RAW_W-1];
      for (int s = 1; s <= NS; s++) begin
        rem_q[s] <= rem_w[s];
        sh_q[s]  <= {sh_q[s-1][QMAG_W-2:0], ge_w[s]};
        dv_q[s]  <= dv_q[s-1];
        neg_q[s] <= neg_q[s-1];
      end
    end
  end

  assign valid_o = vld_q[NS];
  assign neg_o   = neg_q[NS];
  assign mag_o   = sh_q[NS];

endmodule

// ----- design/bptc_poly.sv -----
// ----------------------------------------------------------------------------
// bptc_poly
// Eleven-stage polynomial datapath: temperature result and the pressure sum
// in Pa with 24 fractional bits. Wide products are split in two halves.
// ----------------------------------------------------------------------------
module bptc_poly (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  bptc_pkg::coef_t                    coef_i,
  input  logic [bptc_pkg::QMAG_W-1:0]        t_mag_i,
  input  logic                               t_neg_i,
  input  logic [bptc_pkg::QMAG_W-1:0]        p_mag_i,
  input  logic                               p_neg_i,
  output logic                               valid_o,
  output logic signed [bptc_pkg::SUM_W-1:0]  sum_o,
  output logic [bptc_pkg::TEMP_W-1:0]        temp_o
);
  import bptc_pkg::*;

  localparam int NST    = 11;
  localparam int SC_W   = QMAG_W + 1;
  localparam int PR_W   = 16 + SC_W;
  localparam int P1_W   = 12 + SC_W;
  localparam int A_W    = PR_W + 1;
  localparam int AMAG_W = A_W - 1;
  localparam int ALO    = 23;
  localparam int AHI    = AMAG_W - ALO;
  localparam int PAL_W  = QMAG_W + ALO;
  localparam int PAH_W  = QMAG_W + AHI;
  localparam int FA_W   = PAH_W + ALO;
  localparam int MA_W   = FA_W - FRAC_W;
  localparam int B_W    = MA_W + 1;
  localparam int BMAG_W = MA_W;
  localparam int BLO    = 27;
  localparam int BHI    = BMAG_W - BLO;
  localparam int PBL_W  = QMAG_W + BLO;
  localparam int PBH_W  = QMAG_W + BHI;
  localparam int FB_W   = PBH_W + BLO;
  localparam int MB_W   = FB_W - FRAC_W;
  localparam int TN_W   = P1_W + 1;
  localparam int T16_W  = TN_W - 16;

  logic [NST-1:0] vld_q;

  // carried operands, indexed by stage
  logic [QMAG_W-1:0]      pmag_q [1:8];
  logic [QMAG_W-1:0]      tmag_q [1:8];
  logic                   pneg_q [1:7];
  logic                   tneg_q [1:7];
  logic signed [PR_W-1:0] s01_q  [2:10];
  logic [TEMP_W-1:0]      temp_q [5:11];

  logic signed [SC_W-1:0]  s1_tsc, s1_psc;
  logic signed [PR_W-1:0]  s2_p30, s2_p21;
  logic signed [P1_W-1:0]  s2_p1;
  logic signed [A_W-1:0]   s3_a, s3_d;
  logic signed [TN_W-1:0]  s3_tn;
  logic [AMAG_W-1:0]       s4_amag, s4_dmag;
  logic                    s4_aneg, s4_dneg;
  logic [T16_W-1:0]        s4_t16;
  logic [PAL_W-1:0]        s5_pal, s5_pdl;
  logic [PAH_W-1:0]        s5_pah, s5_pdh;
  logic                    s5_sa, s5_sd, s6_sa, s6_sd;
  logic [MA_W-1:0]         s6_ma, s6_md;
  logic signed [B_W-1:0]   s7_b, s7_e;
  logic [BMAG_W-1:0]       s8_bmag, s8_emag;
  logic                    s8_sb, s8_se, s9_sb, s9_se, s10_sb, s10_se;
  logic [PBL_W-1:0]        s9_pbl, s9_tel;
  logic [PBH_W-1:0]        s9_pbh, s9_teh;
  logic [MB_W-1:0]         s10_mb, s10_me;
  logic signed [SUM_W-1:0] s11_sum;

  logic signed [SC_W-1:0]  tsc_w, psc_w;
  logic signed [A_W-1:0]   a_w, d_w, a_abs_w, d_abs_w;
  logic signed [TN_W-1:0]  tn_w, tadj_w;
  logic [TEMP_W-1:0]       tsat_w;
  logic [FA_W-1:0]         fa_w, fd_w;
  logic signed [B_W-1:0]   ma_x_w, md_x_w, b_w, e_w, b_abs_w, e_abs_w;
  logic [FB_W-1:0]         fb_w, fe_w;
  logic signed [SUM_W-1:0] mb_x_w, me_x_w, sum_w;

  // stage logic
  always_comb begin
    tsc_w = t_neg_i ? -$signed({1'b0, t_mag_i}) : $signed({1'b0, t_mag_i});
    psc_w = p_neg_i ? -$signed({1'b0, p_mag_i}) : $signed({1'b0, p_mag_i});

    a_w  = (A_W'($signed(coef_i.c20)) <<< FRAC_W) + A_W'(s2_p30);
    d_w  = (A_W'($signed(coef_i.c11)) <<< FRAC_W) + A_W'(s2_p21);
    tn_w = (TN_W'($signed(coef_i.c0)) <<< (FRAC_W - 1)) + TN_W'(s2_p1);

    a_abs_w = s3_a[A_W-1] ? -s3_a : s3_a;
    d_abs_w = s3_d[A_W-1] ? -s3_d : s3_d;
    // truncate toward zero on the shift by 16
    tadj_w  = s3_tn + (s3_tn[TN_W-1] ? $signed(TN_W'(16'hffff)) : $signed(TN_W'(0)));

    if ((&s4_t16[T16_W-1:TEMP_W-1]) || !(|s4_t16[T16_W-1:TEMP_W-1])) begin
      tsat_w = s4_t16[TEMP_W-1:0];
    end else begin
      tsat_w = s4_t16[T16_W-1] ? TEMP_MIN : TEMP_MAX;
    end

    fa_w = {s5_pah, {ALO{1'b0}}} + FA_W'(s5_pal);
    fd_w = {s5_pdh, {ALO{1'b0}}} + FA_W'(s5_pdl);

    ma_x_w = $signed({1'b0, s6_ma});
    md_x_w = $signed({1'b0, s6_md});
    b_w    = (B_W'($signed(coef_i.c10)) <<< FRAC_W) + (s6_sa ? -ma_x_w : ma_x_w);
    e_w    = s6_sd ? -md_x_w : md_x_w;

    b_abs_w = s7_b[B_W-1] ? -s7_b : s7_b;
    e_abs_w = s7_e[B_W-1] ? -s7_e : s7_e;

    fb_w = {s9_pbh, {BLO{1'b0}}} + FB_W'(s9_pbl);
    fe_w = {s9_teh, {BLO{1'b0}}} + FB_W'(s9_tel);

    mb_x_w = $signed({{(SUM_W-MB_W){1'b0}}, s10_mb});
    me_x_w = $signed({{(SUM_W-MB_W){1'b0}}, s10_me});
    sum_w  = (SUM_W'($signed(coef_i.c00)) <<< FRAC_W)
           + (s10_sb ? -mb_x_w : mb_x_w)
           + SUM_W'(s01_q[10])
           + (s10_se ? -me_x_w : me_x_w);
  end

  // advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NST-2:0], valid_i};
    end
  end

  // advance stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_tsc    <= tsc_w;
      s1_psc    <= psc_w;
      pmag_q[1] <= p_mag_i;
      tmag_q[1] <= t_mag_i;
      pneg_q[1] <= p_neg_i;
      tneg_q[1] <= t_neg_i;
      for (int k = 2; k <= 8; k++) begin
        pmag_q[k] <= pmag_q[k-1];
        tmag_q[k] <= tmag_q[k-1];
      end
      for (int k = 2; k <= 7; k++) begin
        pneg_q[k] <= pneg_q[k-1];
        tneg_q[k] <= tneg_q[k-1];
      end

      s2_p30   <= $signed(coef_i.c30) * s1_psc;
      s2_p21   <= $signed(coef_i.c21) * s1_psc;
      s2_p1    <= $signed(coef_i.c1) * s1_tsc;
      s01_q[2] <= $signed(coef_i.c01) * s1_tsc;
      for (int k = 3; k <= 10; k++) begin
        s01_q[k] <= s01_q[k-1];
      end

      s3_a  <= a_w;
      s3_d  <= d_w;
      s3_tn <= tn_w;

      s4_amag <= a_abs_w[AMAG_W-1:0];
      s4_dmag <= d_abs_w[AMAG_W-1:0];
      s4_aneg <= s3_a[A_W-1];
      s4_dneg <= s3_d[A_W-1];
      s4_t16  <= tadj_w[TN_W-1:16];

      s5_pal    <= pmag_q[4] * s4_amag[ALO-1:0];
      s5_pah    <= pmag_q[4] * s4_amag[AMAG_W-1:ALO];
      s5_pdl    <= pmag_q[4] * s4_dmag[ALO-1:0];
      s5_pdh    <= pmag_q[4] * s4_dmag[AMAG_W-1:ALO];
      s5_sa     <= pneg_q[4] ^ s4_aneg;
      s5_sd     <= pneg_q[4] ^ s4_dneg;
      temp_q[5] <= tsat_w;
      for (int k = 6; k <= 11; k++) begin
        temp_q[k] <= temp_q[k-1];
      end

      s6_ma <= fa_w[FA_W-1:FRAC_W];
      s6_md <= fd_w[FA_W-1:FRAC_W];
      s6_sa <= s5_sa;
      s6_sd <= s5_sd;

      s7_b <= b_w;
      s7_e <= e_w;

      s8_bmag <= b_abs_w[BMAG_W-1:0];
      s8_emag <= e_abs_w[BMAG_W-1:0];
      s8_sb   <= pneg_q[7] ^ s7_b[B_W-1];
      s8_se   <= tneg_q[7] ^ s7_e[B_W-1];

      s9_pbl <= pmag_q[8] * s8_bmag[BLO-1:0];
      s9_pbh <= pmag_q[8] * s8_bmag[BMAG_W-1:BLO];
      s9_tel <= tmag_q[8] * s8_emag[BLO-1:0];
      s9_teh <= tmag_q[8] * s8_emag[BMAG_W-1:BLO];
      s9_sb  <= s8_sb;
      s9_se  <= s8_se;

      s10_mb <= fb_w[FB_W-1:FRAC_W];
      s10_me <= fe_w[FB_W-1:FRAC_W];
      s10_sb <= s9_sb;
      s10_se <= s9_se;

      s11_sum <= sum_w;
    end
  end

  assign valid_o = vld_q[NST-1];
  assign sum_o   = s11_sum;
  assign temp_o  = temp_q[11];

endmodule

// ----- design/bptc_pdiv.sv -----
// ----------------------------------------------------------------------------
// bptc_pdiv
// Pressure output: truncate the sum toward zero by 1638400 (shift by 16,
// then divide by 25 one hex digit per stage), saturate, register results.
// ----------------------------------------------------------------------------
module bptc_pdiv (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [bptc_pkg::SUM_W-1:0] sum_i,
  input  logic [bptc_pkg::TEMP_W-1:0]       temp_i,
  output logic                              valid_o,
  output logic [bptc_pkg::TEMP_W-1:0]       temp_o,
  output logic [bptc_pkg::PRESS_W-1:0]      press_o
);
  import bptc_pkg::*;

  localparam int NDG   = PMAG_W / DIG_W;
  localparam int R_W   = 5;
  localparam int V_W   = R_W + DIG_W;
  localparam int PRD_W = 15;
  localparam int RSH   = 10;
  localparam logic [5:0]     RECIP25 = 6'd41;
  localparam logic [V_W-1:0] DIV_K   = 9'd25;

  logic [NDG+1:0]      vld_q;
  logic [R_W-1:0]      rem_q [0:NDG];
  logic [PMAG_W-1:0]   sh_q  [0:NDG];
  logic                sat_q [0:NDG];
  logic                neg_q [0:NDG];
  logic [TEMP_W-1:0]   tmp_q [0:NDG];
  logic [TEMP_W-1:0]   temp_out_q;
  logic [PRESS_W-1:0]  press_out_q;

  logic [SUM_W-1:0]    abs_w;
  logic [PM_W-1:0]     m_w;
  logic [V_W-1:0]      v_w   [1:NDG];
  logic [PRD_W-1:0]    prd_w [1:NDG];
  logic [DIG_W-1:0]    dg_w  [1:NDG];
  logic [V_W-1:0]      r_w   [1:NDG];
  logic [PRESS_W-1:0]  q_w, press_w;

  // magnitude, saturation test, digit steps and final sign
  always_comb begin
    abs_w = sum_i[SUM_W-1] ? SUM_W'(-sum_i) : SUM_W'(sum_i);
    m_w   = abs_w[SUM_W-1:16];
    for (int k = 1; k <= NDG; k++) begin
      v_w[k]   = {rem_q[k-1], sh_q[k-1][PMAG_W-1 -: DIG_W]};
      prd_w[k] = PRD_W'(v_w[k]) * PRD_W'(RECIP25);
      dg_w[k]  = prd_w[k][RSH +: DIG_W];
      r_w[k]   = v_w[k] - (V_W'(dg_w[k]) * DIV_K);
    end
    q_w = sh_q[NDG][PRESS_W-1:0];
    if (sat_q[NDG]) begin
      press_w = neg_q[NDG] ? PRESS_MIN : PRESS_MAX;
    end else begin
      press_w = neg_q[NDG] ? -q_w : q_w;
    end
  end

  // advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NDG:0], valid_i};
    end
  end

  // advance stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= '0;
      sh_q[0]  <= m_w[PMAG_W-1:0];
      sat_q[0] <= m_w >= PSAT_LIM;
      neg_q[0] <= sum_i[SUM_W-1];
      tmp_q[0] <= temp_i;
      for (int k = 1; k <= NDG; k++) begin
        rem_q[k] <= r_w[k][R_W-1:0];
        sh_q[k]  <= {sh_q[k-1][PMAG_W-DIG_W-1:0], dg_w[k]};
        sat_q[k] <= sat_q[k-1];
        neg_q[k] <= neg_q[k-1];
        tmp_q[k] <= tmp_q[k-1];
      end
      temp_out_q  <= tmp_q[NDG];
      press_out_q <= press_w;
    end
  end

  assign valid_o = vld_q[NDG+1];
  assign temp_o  = temp_out_q;
  assign press_o = press_out_q;

endmodule

// ----- design/bptc_checker.sv -----
// ----------------------------------------------------------------------------
// bptc_checker
// Port-level checks of the compensation block, bound to the top level.
// ----------------------------------------------------------------------------
module bptc_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_stall_o,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic signed [bptc_pkg::TEMP_W-1:0]   temperature_q_o,
  input logic signed [bptc_pkg::PRESS_W-1:0]  pressure_q_o
);

  // a held result stays put until it transfers
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(temperature_q_o)
                                    && $stable(pressure_q_o))
    else $error("result changed while held");

  // input is stalled exactly when a result waits
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output hold");

  // no result during reset
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result shown during reset");

endmodule

bind baro_temp_pressure_compensation bptc_checker u_checker (.*);
